// ===== rtl/core/astm_pkg.sv =====
// Shared constants and types for the affine span texture mapper.
`timescale 1ns / 1ps
`default_nettype none

package astm_pkg;

    // Request codes
    localparam logic [1:0] REQ_LOAD_TEXEL = 2'd0;
    localparam logic [1:0] REQ_LOAD_CMAP  = 2'd1;
    localparam logic [1:0] REQ_DRAW_SPAN  = 2'd2;
    // Unused code; the block drops such a request
    localparam logic [1:0] REQ_RESERVED   = 2'd3;

    // Field widths
    localparam int REQ_W      = 2;
    localparam int COORD_W    = 32;
    localparam int COUNT_W    = 7;
    localparam int OFFSET_W   = 6;
    localparam int TEXEL_W    = 8;
    localparam int INDEX_W    = 12;

    // Stores
    localparam int TILE_DIM_W  = 6;
    localparam int TEX_ADDR_W  = 2 * TILE_DIM_W;
    localparam int TEX_DEPTH   = 1 << TEX_ADDR_W;
    localparam int CMAP_ADDR_W = 8;
    localparam int CMAP_DEPTH  = 1 << CMAP_ADDR_W;

    // Integer part of a 16.16 coordinate starts here
    localparam int FRAC_W = 16;

    // Longest span in pixels
    localparam logic [COUNT_W-1:0] MAX_RUN = 7'd64;

    // Tag that follows a pixel through the read pipeline
    typedef struct packed {
        logic [OFFSET_W-1:0] offset;
        logic                last;
    } pix_tag_t;

endpackage

`default_nettype wire

// ===== rtl/core/astm_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none

module astm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read; hold the data while the read is not enabled
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/affine_span_texture_mapper_unit.sv =====
// Top level of the affine span texture mapper: span walker and texel/colormap read pipeline.
//
// Usage: one request channel (s_*) and one pixel channel (m_*), both valid/ready.
// A request is a texel load, a colormap load or a span draw. Loads write the
// 64x64 texel tile or the 256-entry colormap and produce no pixel. A span draw
// walks u and v in 16.16 fixed point and emits pixel_count pixels (1..64, larger
// counts are clamped to 64, zero emits nothing), each the colormapped texel at
// (v[21:16], u[21:16]), with its offset in the span and a last flag on the final one.
// The first pixel of a span passes the walker register, the texel RAM read and then
// the colormap RAM read before it is presented. Pixels then follow one per cycle
// while m_ready stays high; a load or an empty span leaves s_ready high. The single
// read port of each RAM sets the pixel rate. s_ready is high only when no pixel is
// in flight, so a new request waits until the previous span has fully drained.
// When m_ready is low under a valid pixel, the whole read pipeline freezes and the
// RAM outputs hold; nothing is dropped. Reset clears the walker and pipeline
// valids; the RAM contents are undefined until written.
`timescale 1ns / 1ps
`default_nettype none

module affine_span_texture_mapper_unit (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [astm_pkg::REQ_W-1:0]      s_req_type,
    input  wire logic [astm_pkg::INDEX_W-1:0]    s_load_index,
    input  wire logic [astm_pkg::TEXEL_W-1:0]    s_load_value,
    input  wire logic [astm_pkg::COORD_W-1:0]    s_u_start,
    input  wire logic [astm_pkg::COORD_W-1:0]    s_v_start,
    input  wire logic [astm_pkg::COORD_W-1:0]    s_u_step,
    input  wire logic [astm_pkg::COORD_W-1:0]    s_v_step,
    input  wire logic [astm_pkg::COUNT_W-1:0]    s_pixel_count,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic      [astm_pkg::TEXEL_W-1:0]    m_pixel_value,
    output logic      [astm_pkg::OFFSET_W-1:0]   m_pixel_offset,
    output logic                                 m_last_pixel
);

    // Walker state
    logic                              active_reg, active_next;
    logic [astm_pkg::COORD_W-1:0]      u_reg, u_next;
    logic [astm_pkg::COORD_W-1:0]      v_reg, v_next;
    logic [astm_pkg::COORD_W-1:0]      du_reg, du_next;
    logic [astm_pkg::COORD_W-1:0]      dv_reg, dv_next;
    logic [astm_pkg::COUNT_W-1:0]      cnt_reg, cnt_next;
    logic [astm_pkg::OFFSET_W-1:0]     offset_reg, offset_next;

    // Read pipeline stages
    logic                              b_valid_reg, b_valid_next;
    astm_pkg::pix_tag_t                b_tag_reg, b_tag_next;
    logic                              c_valid_reg, c_valid_next;
    astm_pkg::pix_tag_t                c_tag_reg, c_tag_next;

    logic                              accept;
    logic                              advance;
    logic                              issue;
    logic                              issue_last;
    logic [astm_pkg::COUNT_W-1:0]      span_len;
    logic                              span_start;
    logic                              tex_wr_en;
    logic                              cmap_wr_en;
    logic [astm_pkg::TEX_ADDR_W-1:0]   tex_rd_addr;
    logic [astm_pkg::TEXEL_W-1:0]      tex_rd_data;
    logic [astm_pkg::TEXEL_W-1:0]      cmap_rd_data;

    // Handshake: take a request only when nothing is in flight
    assign s_ready = !active_reg && !b_valid_reg && !c_valid_reg;
    assign accept  = s_valid && s_ready;
    assign advance = !c_valid_reg || m_ready;

    // Clamp the span length
    assign span_len   = (s_pixel_count > astm_pkg::MAX_RUN) ? astm_pkg::MAX_RUN : s_pixel_count;
    assign span_start = accept && (s_req_type == astm_pkg::REQ_DRAW_SPAN)
                        && (s_pixel_count != '0);

    // Load decode; colormap loads beyond its depth are dropped
    assign tex_wr_en  = accept && (s_req_type == astm_pkg::REQ_LOAD_TEXEL);
    assign cmap_wr_en = accept && (s_req_type == astm_pkg::REQ_LOAD_CMAP)
                        && (s_load_index[astm_pkg::INDEX_W-1:astm_pkg::CMAP_ADDR_W] == '0);

    assign issue      = active_reg && advance;
    assign issue_last = (cnt_reg == astm_pkg::COUNT_W'(1));

    // Tile address: row from v, column from u
    assign tex_rd_addr = {v_reg[astm_pkg::FRAC_W +: astm_pkg::TILE_DIM_W],
                          u_reg[astm_pkg::FRAC_W +: astm_pkg::TILE_DIM_W]};

    // Walker: start on a span request, advance one pixel per free cycle
    always_comb begin
        active_next = active_reg;
        u_next      = u_reg;
        v_next      = v_reg;
        du_next     = du_reg;
        dv_next     = dv_reg;
        cnt_next    = cnt_reg;
        offset_next = offset_reg;
        if (span_start) begin
            active_next = 1'b1;
            u_next      = s_u_start;
            v_next      = s_v_start;
            du_next     = s_u_step;
            dv_next     = s_v_step;
            cnt_next    = span_len;
            offset_next = '0;
        end else if (issue) begin
            u_next      = u_reg + du_reg;
            v_next      = v_reg + dv_reg;
            cnt_next    = cnt_reg - astm_pkg::COUNT_W'(1);
            offset_next = offset_reg + astm_pkg::OFFSET_W'(1);
            if (issue_last) begin
                active_next = 1'b0;
            end
        end
    end

    // Pipeline valids and tags move only when the output can advance
    always_comb begin
        b_valid_next = b_valid_reg;
        b_tag_next   = b_tag_reg;
        c_valid_next = c_valid_reg;
        c_tag_next   = c_tag_reg;
        if (advance) begin
            b_valid_next      = active_reg;
            b_tag_next.offset = offset_reg;
            b_tag_next.last   = issue_last;
            c_valid_next      = b_valid_reg;
            c_tag_next        = b_tag_reg;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end else begin
            active_reg  <= active_next;
            b_valid_reg <= b_valid_next;
            c_valid_reg <= c_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        u_reg      <= u_next;
        v_reg      <= v_next;
        du_reg     <= du_next;
        dv_reg     <= dv_next;
        cnt_reg    <= cnt_next;
        offset_reg <= offset_next;
        b_tag_reg  <= b_tag_next;
        c_tag_reg  <= c_tag_next;
    end

    // Texel tile
    astm_ram #(
        .WIDTH (astm_pkg::TEXEL_W),
        .DEPTH (astm_pkg::TEX_DEPTH)
    ) u_texel_ram (
        .aclk    (aclk),
        .wr_en   (tex_wr_en),
        .wr_addr (s_load_index[astm_pkg::TEX_ADDR_W-1:0]),
        .wr_data (s_load_value),
        .rd_en   (advance),
        .rd_addr (tex_rd_addr),
        .rd_data (tex_rd_data)
    );

    // Light colormap, addressed by the fetched texel
    astm_ram #(
        .WIDTH (astm_pkg::TEXEL_W),
        .DEPTH (astm_pkg::CMAP_DEPTH)
    ) u_cmap_ram (
        .aclk    (aclk),
        .wr_en   (cmap_wr_en),
        .wr_addr (s_load_index[astm_pkg::CMAP_ADDR_W-1:0]),
        .wr_data (s_load_value),
        .rd_en   (advance),
        .rd_addr (tex_rd_data),
        .rd_data (cmap_rd_data)
    );

    // Drive the pixel channel
    assign m_valid        = c_valid_reg;
    assign m_pixel_value  = cmap_rd_data;
    assign m_pixel_offset = c_tag_reg.offset;
    assign m_last_pixel   = c_tag_reg.last;

    // A nonempty span request starts the walker at offset zero
    a_span_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        span_start |=> (active_reg && (offset_reg == '0)))
        else $error("span request did not start the walker");

    // The walker never runs with an exhausted count
    a_count_live: assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg |-> (cnt_reg != '0))
        else $error("walker active with zero pixels left");

    // Issuing the last pixel stops the walker
    a_last_stops: assert property (@(posedge aclk) disable iff (!aresetn)
        (issue && issue_last) |=> (!active_reg && b_valid_reg && b_tag_reg.last))
        else $error("walker kept running after the last pixel");

    // A stalled pixel keeps its colormapped value
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (c_valid_reg && !m_ready) |=> $stable(cmap_rd_data))
        else $error("colormap output changed under stall");

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking testbench for the affine span texture mapper unit.
`timescale 1ns / 1ps

module testbench;

    localparam int IDLE_LIMIT   = 2000;
    localparam int RANDOM_ITEMS = 210;
    localparam int TAIL_CYCLES  = 20;
    // Colormap entries preloaded; preloaded and random texel values stay below this
    localparam int CMAP_FILL    = 64;
    // Tile rows preloaded in full; column zero is preloaded on every row
    localparam int BAND_ROWS    = 2;

    typedef logic [astm_pkg::REQ_W-1:0]      req_t;
    typedef logic [astm_pkg::INDEX_W-1:0]    index_t;
    typedef logic [astm_pkg::TEXEL_W-1:0]    texel_t;
    typedef logic [astm_pkg::COORD_W-1:0]    coord_t;
    typedef logic [astm_pkg::COUNT_W-1:0]    count_t;
    typedef logic [astm_pkg::OFFSET_W-1:0]   offset_t;
    typedef logic [astm_pkg::TEX_ADDR_W-1:0] tex_addr_t;

    typedef struct packed {
        req_t   req_type;
        index_t load_index;
        texel_t load_value;
        coord_t u_start;
        coord_t v_start;
        coord_t u_step;
        coord_t v_step;
        count_t pixel_count;
    } span_req_t;

    typedef struct packed {
        texel_t  value;
        offset_t offset;
        logic    last;
    } pixel_t;

    // Mirror of both stores plus the queue of pixels still owed by the block
    class span_pixel_tracker;
        texel_t texels [astm_pkg::TEX_DEPTH];
        texel_t colormap [astm_pkg::CMAP_DEPTH];
        bit     tex_written [astm_pkg::TEX_DEPTH];
        bit     cmap_written [astm_pkg::CMAP_DEPTH];
        pixel_t pending_pixels[$];
        int errors = 0;

        // Span length after clamping to the longest run
        function int span_length(count_t count);
            return (count > astm_pkg::MAX_RUN) ? int'(astm_pkg::MAX_RUN) : int'(count);
        endfunction

        // Tile address of one pixel: row from v, column from u
        function tex_addr_t tile_addr(coord_t u, coord_t v);
            return {v[astm_pkg::FRAC_W +: astm_pkg::TILE_DIM_W],
                    u[astm_pkg::FRAC_W +: astm_pkg::TILE_DIM_W]};
        endfunction

        // True when every pixel of the span reads written texels and colormap entries
        function bit span_is_safe(span_req_t r);
            coord_t    u;
            coord_t    v;
            tex_addr_t addr;
            u = r.u_start;
            v = r.v_start;
            for (int k = 0; k < span_length(r.pixel_count); k++) begin
                addr = tile_addr(u, v);
                if (!tex_written[addr] || !cmap_written[texels[addr]])
                    return 1'b0;
                u = u + r.u_step;
                v = v + r.v_step;
            end
            return 1'b1;
        endfunction

        // Apply one accepted request: update a store or queue the span's pixels
        function void apply_request(span_req_t r);
            coord_t    u;
            coord_t    v;
            tex_addr_t addr;
            int        count;
            pixel_t    px;
            case (r.req_type)
                astm_pkg::REQ_LOAD_TEXEL: begin
                    texels[r.load_index]      = r.load_value;
                    tex_written[r.load_index] = 1'b1;
                end
                astm_pkg::REQ_LOAD_CMAP: begin
                    if (r.load_index < astm_pkg::CMAP_DEPTH) begin
                        colormap[r.load_index[astm_pkg::CMAP_ADDR_W-1:0]]     = r.load_value;
                        cmap_written[r.load_index[astm_pkg::CMAP_ADDR_W-1:0]] = 1'b1;
                    end
                end
                astm_pkg::REQ_DRAW_SPAN: begin
                    count = span_length(r.pixel_count);
                    u = r.u_start;
                    v = r.v_start;
                    for (int k = 0; k < count; k++) begin
                        addr = tile_addr(u, v);
                        px.value  = colormap[texels[addr]];
                        px.offset = k[astm_pkg::OFFSET_W-1:0];
                        px.last   = (k + 1 == count);
                        pending_pixels.push_back(px);
                        u = u + r.u_step;
                        v = v + r.v_step;
                    end
                end
                default: ;
            endcase
        endfunction

        // Compare one accepted pixel with the oldest one owed
        function void check_pixel(pixel_t got);
            pixel_t want;
            if (pending_pixels.size() == 0) begin
                $display("%0t: unexpected pixel value=%0d offset=%0d last=%0d",
                         $time, got.value, got.offset, got.last);
                errors++;
                return;
            end
            want = pending_pixels.pop_front();
            if (got.value !== want.value) begin
                $display("%0t: pixel_value expected %0d actual %0d",
                         $time, want.value, got.value);
                errors++;
            end
            if (got.offset !== want.offset) begin
                $display("%0t: pixel_offset expected %0d actual %0d",
                         $time, want.offset, got.offset);
                errors++;
            end
            if (got.last !== want.last) begin
                $display("%0t: last_pixel expected %0d actual %0d",
                         $time, want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic     aclk          = 1'b0;
    logic     aresetn       = 1'b0;
    logic     s_valid       = 1'b0;
    logic     s_ready;
    req_t     s_req_type    = '0;
    index_t   s_load_index  = '0;
    texel_t   s_load_value  = '0;
    coord_t   s_u_start     = '0;
    coord_t   s_v_start     = '0;
    coord_t   s_u_step      = '0;
    coord_t   s_v_step      = '0;
    count_t   s_pixel_count = '0;
    logic     m_valid;
    logic     m_ready       = 1'b0;
    texel_t   m_pixel_value;
    offset_t  m_pixel_offset;
    logic     m_last_pixel;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int idle_cycles    = 0;

    span_pixel_tracker board = new();

    affine_span_texture_mapper_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_load_index  (s_load_index),
        .s_load_value  (s_load_value),
        .s_u_start     (s_u_start),
        .s_v_start     (s_v_start),
        .s_u_step      (s_u_step),
        .s_v_step      (s_v_step),
        .s_pixel_count (s_pixel_count),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_value (m_pixel_value),
        .m_pixel_offset(m_pixel_offset),
        .m_last_pixel  (m_last_pixel)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Check accepted pixels, then pick the next cycle's ready
    always @(posedge aclk) begin
        if (m_valid && m_ready)
            board.check_pixel('{m_pixel_value, m_pixel_offset, m_last_pixel});
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Abort when neither channel moves for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic span_req_t make_load(req_t kind, index_t index, texel_t value);
        span_req_t r;
        r.req_type    = kind;
        r.load_index  = index;
        r.load_value  = value;
        r.u_start     = $urandom();
        r.v_start     = $urandom();
        r.u_step      = $urandom();
        r.v_step      = $urandom();
        r.pixel_count = count_t'($urandom_range(0, 127));
        return r;
    endfunction

    function automatic span_req_t make_span(coord_t u, coord_t v, coord_t du, coord_t dv,
                                            count_t count);
        span_req_t r;
        r.req_type    = astm_pkg::REQ_DRAW_SPAN;
        r.load_index  = index_t'($urandom_range(0, astm_pkg::TEX_DEPTH - 1));
        r.load_value  = texel_t'($urandom_range(0, 255));
        r.u_start     = u;
        r.v_start     = v;
        r.u_step      = du;
        r.v_step      = dv;
        r.pixel_count = count;
        return r;
    endfunction

    // Hold off at random, present the request, hold it until accepted
    task automatic send_request(span_req_t r);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_req_type    <= r.req_type;
        s_load_index  <= r.load_index;
        s_load_value  <= r.load_value;
        s_u_start     <= r.u_start;
        s_v_start     <= r.v_start;
        s_u_step      <= r.u_step;
        s_v_step      <= r.v_step;
        s_pixel_count <= r.pixel_count;
        do @(posedge aclk); while (!(s_valid && s_ready));
        board.apply_request(r);
    endtask

    // Pick a step: either a small signed walk or anything at all
    function automatic coord_t pick_step(bit coherent);
        if (coherent)
            return $urandom_range(0, 32'h3ffff) - 32'h20000;
        return $urandom();
    endfunction

    // Span that stays on preloaded texels: along a filled row or down column zero
    function automatic span_req_t make_walk_span(count_t count, bit coherent);
        coord_t u;
        coord_t v;
        coord_t du;
        coord_t dv;
        u  = $urandom();
        v  = $urandom();
        du = pick_step(coherent);
        dv = pick_step(coherent);
        if ($urandom_range(1) == 0) begin
            v[astm_pkg::FRAC_W +: astm_pkg::TILE_DIM_W] =
                astm_pkg::TILE_DIM_W'($urandom_range(0, BAND_ROWS - 1));
            dv[astm_pkg::FRAC_W + astm_pkg::TILE_DIM_W - 1:0] = '0;
        end else begin
            u[astm_pkg::FRAC_W +: astm_pkg::TILE_DIM_W] = '0;
            du[astm_pkg::FRAC_W + astm_pkg::TILE_DIM_W - 1:0] = '0;
        end
        return make_span(u, v, du, dv, count);
    endfunction

    // Random request mix; returns 1 when the request does real work
    task automatic send_random_request(output bit counted);
        int        pick;
        bit        coherent;
        count_t    count;
        index_t    index;
        span_req_t r;
        pick = $urandom_range(99);
        if (pick < 12) begin
            r = make_load(astm_pkg::REQ_LOAD_TEXEL,
                          index_t'($urandom_range(0, astm_pkg::TEX_DEPTH - 1)),
                          texel_t'($urandom_range(0, CMAP_FILL - 1)));
            counted = 1'b1;
        end else if (pick < 20) begin
            index = ($urandom_range(99) < 80)
                    ? index_t'($urandom_range(0, astm_pkg::CMAP_DEPTH - 1))
                    : index_t'($urandom_range(0, astm_pkg::TEX_DEPTH - 1));
            r = make_load(astm_pkg::REQ_LOAD_CMAP, index, texel_t'($urandom_range(0, 255)));
            counted = (index < astm_pkg::CMAP_DEPTH);
        end else if (pick < 23) begin
            r = make_load(astm_pkg::REQ_RESERVED,
                          index_t'($urandom_range(0, astm_pkg::TEX_DEPTH - 1)),
                          texel_t'($urandom_range(0, 255)));
            counted = 1'b0;
        end else begin
            pick = $urandom_range(99);
            if (pick < 70)
                count = count_t'($urandom_range(1, 16));
            else if (pick < 90)
                count = count_t'($urandom_range(1, 64));
            else
                count = count_t'($urandom_range(0, 127));
            coherent = ($urandom_range(1) == 0);
            r = make_span($urandom(), $urandom(), pick_step(coherent), pick_step(coherent),
                          count);
            // Fall back to a walk over preloaded texels when the span strays
            if (!board.span_is_safe(r))
                r = make_walk_span(count, coherent);
            counted = (count != 0);
        end
        send_request(r);
    endtask

    initial begin
        int  done;
        bit  counted;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Preload the colormap head, the first tile rows and column zero
        for (int i = 0; i < CMAP_FILL; i++)
            send_request(make_load(astm_pkg::REQ_LOAD_CMAP, index_t'(i),
                                   texel_t'($urandom_range(0, 255))));
        for (int i = 0; i < astm_pkg::TEX_DEPTH; i++) begin
            if ((i < (BAND_ROWS << astm_pkg::TILE_DIM_W))
                || (i[astm_pkg::TILE_DIM_W-1:0] == '0))
                send_request(make_load(astm_pkg::REQ_LOAD_TEXEL, index_t'(i),
                                       texel_t'($urandom_range(0, CMAP_FILL - 1))));
        end

        // Directed corners
        send_idle_pct  = 27;
        recv_stall_pct = 27;
        send_request(make_load(astm_pkg::REQ_LOAD_TEXEL, 12'hfff, 8'hff));
        send_request(make_load(astm_pkg::REQ_LOAD_TEXEL, 12'h000, 8'h00));
        send_request(make_load(astm_pkg::REQ_LOAD_CMAP, 12'd255, 8'hff));
        send_request(make_load(astm_pkg::REQ_LOAD_CMAP, 12'd0, 8'h00));
        send_request(make_load(astm_pkg::REQ_LOAD_CMAP, 12'd256, 8'h5a));
        send_request(make_load(astm_pkg::REQ_LOAD_CMAP, 12'hfff, 8'ha5));
        send_request(make_load(astm_pkg::REQ_RESERVED, 12'hfff, 8'hff));
        send_request(make_span('0, '0, '0, '0, 7'd1));
        send_request(make_span('0, '0, '0, '0, 7'd0));
        send_request(make_span('1, '1, '1, '1, 7'd64));
        send_request(make_span('0, '0, 32'h0001_0000, '0, 7'd64));
        send_request(make_span('0, '0, '0, 32'h0001_0000, 7'd64));
        send_request(make_span(32'h003f_0000, 32'h003f_8000, 32'h0001_0000,
                               32'h0000_8000, 7'd5));
        send_request(make_span(32'h1234_5678, 32'h8740_4321, 32'hffff_0000,
                               32'hffc0_0000, 7'd127));
        send_request(make_walk_span(7'd65, 1'b0));
        send_request(make_span($urandom(), 32'h0001_fffe, 32'h0000_0001, 32'h0000_0001,
                               7'd2));
        send_request(make_span(32'hffc0_0000, 32'h0001_c000, 32'h0000_4000,
                               32'hffff_c000, 7'd8));

        // Random requests across the idling phases
        done = 0;
        while (done < RANDOM_ITEMS) begin
            case (done * 4 / RANDOM_ITEMS)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
                default: begin send_idle_pct = 27; recv_stall_pct = 27; end
            endcase
            send_random_request(counted);
            if (counted)
                done++;
        end
        s_valid <= 1'b0;

        // Drain, then give the block time to show any stray pixel
        while (board.pending_pixels.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (board.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
